>>> rtl/core/sgr_pkg.sv
`timescale 1ns / 1ps
// shared constants and the extended color function of the sgr attribute decoder
package sgr_pkg;

    localparam int PARAM_W = 10;
    localparam int COLOR_W = 25;

    // color encoding
    localparam logic [COLOR_W-1:0] SLOT_DEFAULT_BG = 25'd16;
    localparam logic [COLOR_W-1:0] SLOT_DEFAULT_FG = 25'd17;
    localparam logic [COLOR_W-1:0] SLOT_LIGHT_OFS  = 25'd8;

    // sgr parameter codes
    localparam logic [7:0] SGR_RESET        = 8'd0;
    localparam logic [7:0] SGR_BOLD_ON      = 8'd1;
    localparam logic [7:0] SGR_BOLD_OFF     = 8'd2;
    localparam logic [7:0] SGR_ITALIC_ON    = 8'd3;
    localparam logic [7:0] SGR_UNDERLINE_ON = 8'd4;
    localparam logic [7:0] SGR_EXT_INDEXED  = 8'd5;
    localparam logic [7:0] SGR_NORMAL_INT   = 8'd22;
    localparam logic [7:0] SGR_ITALIC_OFF   = 8'd23;
    localparam logic [7:0] SGR_UNDERLINE_OFF = 8'd24;
    localparam logic [7:0] SGR_FG_FIRST     = 8'd30;
    localparam logic [7:0] SGR_FG_LAST      = 8'd37;
    localparam logic [7:0] SGR_FG_EXT       = 8'd38;
    localparam logic [7:0] SGR_BG_DEFAULT   = 8'd39;
    localparam logic [7:0] SGR_BG_FIRST     = 8'd40;
    localparam logic [7:0] SGR_BG_LAST      = 8'd47;
    localparam logic [7:0] SGR_BG_EXT       = 8'd48;

    // extended palette layout
    localparam logic [7:0] EXT_BASE   = 8'd16;
    localparam logic [7:0] GREY_BASE  = 8'd232;
    localparam logic [7:0] CUBE_STEP  = 8'd42;
    localparam logic [7:0] GREY_STEP  = 8'd10;
    localparam logic [5:0] CUBE_PLANE = 6'd36;
    localparam logic [2:0] CUBE_ROW   = 3'd6;

    // reciprocals: x*57>>11 == x/36 for x < 216, x*43>>8 == x/6 for x < 36
    localparam logic [13:0] RECIP_36 = 14'd57;
    localparam logic [10:0] RECIP_6  = 11'd43;

    // index 16..255 to rgb color with the rgb flag set
    function automatic logic [COLOR_W-1:0] ext_color(input logic [7:0] v);
        logic [7:0]  c;
        logic [13:0] p36;
        logic [2:0]  r_idx;
        logic [5:0]  rem;
        logic [10:0] p6;
        logic [2:0]  g_idx;
        logic [2:0]  b_idx;
        logic [4:0]  lvl;
        logic [7:0]  grey;
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        c     = v - EXT_BASE;
        p36   = 14'(c) * RECIP_36;
        r_idx = p36[13:11];
        rem   = 6'(c - 8'(r_idx) * 8'(CUBE_PLANE));
        p6    = 11'(rem) * RECIP_6;
        g_idx = p6[10:8];
        b_idx = 3'(rem - 6'(g_idx) * 6'(CUBE_ROW));
        r8    = 8'(r_idx) * CUBE_STEP;
        g8    = 8'(g_idx) * CUBE_STEP;
        b8    = 8'(b_idx) * CUBE_STEP;
        lvl   = 5'(v - GREY_BASE);
        grey  = 8'(lvl) * GREY_STEP;
        if (v < GREY_BASE) begin
            ext_color = {1'b1, r8, g8, b8};
        end else begin
            ext_color = {1'b1, grey, grey, grey};
        end
    endfunction

endpackage

>>> rtl/core/sgr_attribute_decoder.sv
`timescale 1ns / 1ps
// sgr attribute decoder: applies one sgr parameter per transfer and reports the attributes
// path: an input transfer enters the input register, and its result the state/result register
// throughput: one parameter per cycle while results are taken; the attribute update is
//   combinational logic between the input register and the state/result registers
// reset: synchronous active low; clears pipeline valids, extended-color mode bits,
//   sets fg and light fg to the default fg slot, bg to the default bg slot, flags off
// a stalled result holds the state; one more parameter waits in the input register
module sgr_attribute_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sgr_pkg::PARAM_W-1:0] i_param_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sgr_pkg::COLOR_W-1:0] o_fg_color,
    output logic [sgr_pkg::COLOR_W-1:0] o_fg_light_color,
    output logic [sgr_pkg::COLOR_W-1:0] o_bg_color,
    output logic                        o_bold_on,
    output logic                        o_italic_on,
    output logic                        o_underline_on
);

    // input register stage
    logic       r_s1_valid;
    logic [7:0] r_param;

    // attribute state, which is also the result register
    logic                        r_out_valid;
    logic                        r_ext, n_ext;
    logic                        r_fg_pend, n_fg_pend;
    logic                        r_bg_pend, n_bg_pend;
    logic                        r_await, n_await;
    logic [sgr_pkg::COLOR_W-1:0] r_fg, n_fg;
    logic [sgr_pkg::COLOR_W-1:0] r_fg_light, n_fg_light;
    logic [sgr_pkg::COLOR_W-1:0] r_bg, n_bg;
    logic                        r_bold, n_bold;
    logic                        r_italic, n_italic;
    logic                        r_uline, n_uline;

    logic       s2_adv;
    logic       serve;
    logic       do_ordinary;
    logic [7:0] v;
    logic [sgr_pkg::COLOR_W-1:0] ext_rgb;

    // the update stage moves when the result slot is empty or being taken
    assign s2_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s2_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        // oversized parameters saturate to 255 on the way in
        if (o_ready && i_valid) begin
            r_param <= (|i_param_value[sgr_pkg::PARAM_W-1:8]) ? 8'hFF : i_param_value[7:0];
        end
    end

    assign v       = r_param;
    assign ext_rgb = sgr_pkg::ext_color(v);
    // an extended index is expected and a request is pending
    assign serve   = r_await && (r_fg_pend || r_bg_pend);

    always_comb begin
        n_ext       = r_ext;
        n_fg_pend   = r_fg_pend;
        n_bg_pend   = r_bg_pend;
        n_await     = r_await;
        n_fg        = r_fg;
        n_fg_light  = r_fg_light;
        n_bg        = r_bg;
        n_bold      = r_bold;
        n_italic    = r_italic;
        n_uline     = r_uline;
        do_ordinary = 1'b0;

        priority if (serve) begin
            // foreground request wins when both are pending
            if (r_fg_pend) begin
                n_fg_pend = 1'b0;
            end else begin
                n_bg_pend = 1'b0;
            end
            n_await = 1'b0;
            n_ext   = 1'b0;
            if (v < sgr_pkg::EXT_BASE) begin
                // low index falls back to normal handling
                do_ordinary = 1'b1;
            end else if (r_fg_pend) begin
                n_fg = ext_rgb;
            end else begin
                n_bg = ext_rgb;
            end
        end else if (v == sgr_pkg::SGR_FG_EXT) begin
            n_ext     = 1'b1;
            n_fg_pend = 1'b1;
        end else if (v == sgr_pkg::SGR_BG_EXT) begin
            n_ext     = 1'b1;
            n_bg_pend = 1'b1;
        end else if (r_ext && v == sgr_pkg::SGR_EXT_INDEXED) begin
            n_await = 1'b1;
        end else begin
            do_ordinary = 1'b1;
        end

        if (do_ordinary) begin
            priority if (v == sgr_pkg::SGR_RESET) begin
                n_ext      = 1'b0;
                n_fg_pend  = 1'b0;
                n_bg_pend  = 1'b0;
                n_await    = 1'b0;
                n_fg       = sgr_pkg::SLOT_DEFAULT_FG;
                n_fg_light = sgr_pkg::SLOT_DEFAULT_FG;
                n_bg       = sgr_pkg::SLOT_DEFAULT_BG;
                n_bold     = 1'b0;
                n_italic   = 1'b0;
                n_uline    = 1'b0;
            end else if (v == sgr_pkg::SGR_BOLD_ON) begin
                n_bold = 1'b1;
            end else if (v == sgr_pkg::SGR_BOLD_OFF || v == sgr_pkg::SGR_NORMAL_INT) begin
                n_bold = 1'b0;
            end else if (v == sgr_pkg::SGR_ITALIC_ON) begin
                n_italic = 1'b1;
            end else if (v == sgr_pkg::SGR_ITALIC_OFF) begin
                n_italic = 1'b0;
            end else if (v == sgr_pkg::SGR_UNDERLINE_ON) begin
                n_uline = 1'b1;
            end else if (v == sgr_pkg::SGR_UNDERLINE_OFF) begin
                n_uline = 1'b0;
            end else if (v >= sgr_pkg::SGR_FG_FIRST && v <= sgr_pkg::SGR_FG_LAST) begin
                // normal palette slot and its light partner
                n_fg       = 25'(v - sgr_pkg::SGR_FG_FIRST);
                n_fg_light = 25'(v - sgr_pkg::SGR_FG_FIRST) + sgr_pkg::SLOT_LIGHT_OFS;
            end else if (v == sgr_pkg::SGR_BG_DEFAULT) begin
                n_bg = sgr_pkg::SLOT_DEFAULT_BG;
            end else if (v >= sgr_pkg::SGR_BG_FIRST && v <= sgr_pkg::SGR_BG_LAST) begin
                n_bg = 25'(v - sgr_pkg::SGR_BG_FIRST);
            end else begin
                // unknown parameters leave everything as is
                n_bold = r_bold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ext       <= 1'b0;
            r_fg_pend   <= 1'b0;
            r_bg_pend   <= 1'b0;
            r_await     <= 1'b0;
            r_fg        <= sgr_pkg::SLOT_DEFAULT_FG;
            r_fg_light  <= sgr_pkg::SLOT_DEFAULT_FG;
            r_bg        <= sgr_pkg::SLOT_DEFAULT_BG;
            r_bold      <= 1'b0;
            r_italic    <= 1'b0;
            r_uline     <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_out_valid <= 1'b1;
                r_ext       <= n_ext;
                r_fg_pend   <= n_fg_pend;
                r_bg_pend   <= n_bg_pend;
                r_await     <= n_await;
                r_fg        <= n_fg;
                r_fg_light  <= n_fg_light;
                r_bg        <= n_bg;
                r_bold      <= n_bold;
                r_italic    <= n_italic;
                r_uline     <= n_uline;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fg_color       = r_fg;
    assign o_fg_light_color = r_fg_light;
    assign o_bg_color       = r_bg;
    assign o_bold_on        = r_bold;
    assign o_italic_on      = r_italic;
    assign o_underline_on   = r_uline;

    // extended mode never stands without a pending request
    a_ext_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ext |-> (r_fg_pend || r_bg_pend))
        else $error("extended mode without pending request");

    // waiting for an index only happens inside extended mode
    a_await_in_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> r_ext)
        else $error("awaiting index outside extended mode");

    // light foreground is always a palette slot
    a_light_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fg_light[sgr_pkg::COLOR_W-1])
        else $error("light foreground holds rgb");

    // a held result keeps the state frozen
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_fg) && $stable(r_bg) && $stable(r_ext)))
        else $error("state changed under a stalled result");

    // a waiting parameter is not dropped while the update stage is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_adv) |=> (r_s1_valid && $stable(r_param)))
        else $error("input register lost a parameter");

endmodule

>>> sim/sgr_checker.sv
`timescale 1ns / 1ps
// attribute predictor and result checker for the sgr attribute decoder
module sgr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [sgr_pkg::PARAM_W-1:0] i_param_value,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [sgr_pkg::COLOR_W-1:0] i_fg_color,
    input  logic [sgr_pkg::COLOR_W-1:0] i_fg_light_color,
    input  logic [sgr_pkg::COLOR_W-1:0] i_bg_color,
    input  logic                        i_bold_on,
    input  logic                        i_italic_on,
    input  logic                        i_underline_on,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef logic [sgr_pkg::COLOR_W-1:0] t_color;

    typedef struct packed {
        t_color fg;
        t_color fg_light;
        t_color bg;
        logic   bold;
        logic   italic;
        logic   underline;
    } t_attr;

    // predicted decoder state
    logic  ext_mode;
    logic  fg_pend;
    logic  bg_pend;
    logic  want_index;
    t_attr attrs;

    t_attr attr_queue[$];
    int    fails = 0;

    function automatic t_color palette_rgb(input logic [7:0] idx);
        int unsigned c;
        int unsigned lvl;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        if (idx < sgr_pkg::GREY_BASE) begin
            c = idx - sgr_pkg::EXT_BASE;
            r = 8'((c / 36) * 42);
            g = 8'(((c % 36) / 6) * 42);
            b = 8'((c % 6) * 42);
        end else begin
            lvl = (idx - sgr_pkg::GREY_BASE) * 10;
            r = 8'(lvl);
            g = 8'(lvl);
            b = 8'(lvl);
        end
        return {1'b1, r, g, b};
    endfunction

    task automatic clear_attrs();
        ext_mode        = 1'b0;
        fg_pend         = 1'b0;
        bg_pend         = 1'b0;
        want_index      = 1'b0;
        attrs.fg        = sgr_pkg::SLOT_DEFAULT_FG;
        attrs.fg_light  = sgr_pkg::SLOT_DEFAULT_FG;
        attrs.bg        = sgr_pkg::SLOT_DEFAULT_BG;
        attrs.bold      = 1'b0;
        attrs.italic    = 1'b0;
        attrs.underline = 1'b0;
    endtask

    task automatic plain_param(input logic [7:0] v);
        if (v == sgr_pkg::SGR_RESET) begin
            clear_attrs();
        end else if (v == sgr_pkg::SGR_BOLD_ON) begin
            attrs.bold = 1'b1;
        end else if (v == sgr_pkg::SGR_BOLD_OFF || v == sgr_pkg::SGR_NORMAL_INT) begin
            attrs.bold = 1'b0;
        end else if (v == sgr_pkg::SGR_ITALIC_ON) begin
            attrs.italic = 1'b1;
        end else if (v == sgr_pkg::SGR_ITALIC_OFF) begin
            attrs.italic = 1'b0;
        end else if (v == sgr_pkg::SGR_UNDERLINE_ON) begin
            attrs.underline = 1'b1;
        end else if (v == sgr_pkg::SGR_UNDERLINE_OFF) begin
            attrs.underline = 1'b0;
        end else if (v >= sgr_pkg::SGR_FG_FIRST && v <= sgr_pkg::SGR_FG_LAST) begin
            attrs.fg       = t_color'(v - sgr_pkg::SGR_FG_FIRST);
            attrs.fg_light = t_color'(v - sgr_pkg::SGR_FG_FIRST) + sgr_pkg::SLOT_LIGHT_OFS;
        end else if (v == sgr_pkg::SGR_BG_DEFAULT) begin
            attrs.bg = sgr_pkg::SLOT_DEFAULT_BG;
        end else if (v >= sgr_pkg::SGR_BG_FIRST && v <= sgr_pkg::SGR_BG_LAST) begin
            attrs.bg = t_color'(v - sgr_pkg::SGR_BG_FIRST);
        end
    endtask

    task automatic take_param(input logic [sgr_pkg::PARAM_W-1:0] raw);
        logic [7:0] v;
        logic       to_fg;
        v = (raw > 255) ? 8'd255 : raw[7:0];
        if (want_index && (fg_pend || bg_pend)) begin
            // foreground request is served first when both are pending
            to_fg = fg_pend;
            if (to_fg) begin
                fg_pend = 1'b0;
            end else begin
                bg_pend = 1'b0;
            end
            want_index = 1'b0;
            ext_mode   = 1'b0;
            if (v < sgr_pkg::EXT_BASE) begin
                plain_param(v);
            end else if (to_fg) begin
                attrs.fg = palette_rgb(v);
            end else begin
                attrs.bg = palette_rgb(v);
            end
        end else if (v == sgr_pkg::SGR_FG_EXT) begin
            ext_mode = 1'b1;
            fg_pend  = 1'b1;
        end else if (v == sgr_pkg::SGR_BG_EXT) begin
            ext_mode = 1'b1;
            bg_pend  = 1'b1;
        end else if (ext_mode && v == sgr_pkg::SGR_EXT_INDEXED) begin
            want_index = 1'b1;
        end else begin
            plain_param(v);
        end
    endtask

    task automatic check_field(input string name, input t_color want, input t_color got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_attr want;
        if (!i_rst_n) begin
            clear_attrs();
            attr_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (attr_queue.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer with none expected, actual fg %h bg %h",
                             $time, i_fg_color, i_bg_color);
                end else begin
                    want = attr_queue.pop_front();
                    check_field("fg_color", want.fg, i_fg_color);
                    check_field("fg_light_color", want.fg_light, i_fg_light_color);
                    check_field("bg_color", want.bg, i_bg_color);
                    check_field("bold_on", t_color'(want.bold), t_color'(i_bold_on));
                    check_field("italic_on", t_color'(want.italic), t_color'(i_italic_on));
                    check_field("underline_on", t_color'(want.underline),
                                t_color'(i_underline_on));
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_param(i_param_value);
                attr_queue.push_back(attrs);
            end
        end
        o_fail_count <= fails;
        o_pending    <= attr_queue.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// testbench top: stimulus, flow control and verdict for the sgr attribute decoder
module tb_top;

    typedef logic [sgr_pkg::PARAM_W-1:0] t_param;

    localparam int N_ITEMS     = 550;
    localparam int CYCLE_LIMIT = 200000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    t_param                      i_param_value = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [sgr_pkg::COLOR_W-1:0] o_fg_color;
    logic [sgr_pkg::COLOR_W-1:0] o_fg_light_color;
    logic [sgr_pkg::COLOR_W-1:0] o_bg_color;
    logic                        o_bold_on;
    logic                        o_italic_on;
    logic                        o_underline_on;

    int chk_fails;
    int chk_pending;

    // parameter stream, filled before reset is released
    t_param param_stream[$];

    int   n_taken = 0;     // accepted input transfers
    int   next_idx = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   cycles = 0;
    logic hold_ready = 1'b0;
    logic idle_ok;

    sgr_attribute_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_param_value    (i_param_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_fg_color       (o_fg_color),
        .o_fg_light_color (o_fg_light_color),
        .o_bg_color       (o_bg_color),
        .o_bold_on        (o_bold_on),
        .o_italic_on      (o_italic_on),
        .o_underline_on   (o_underline_on)
    );

    sgr_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_param_value    (i_param_value),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_fg_color       (o_fg_color),
        .i_fg_light_color (o_fg_light_color),
        .i_bg_color       (o_bg_color),
        .i_bold_on        (o_bold_on),
        .i_italic_on      (o_italic_on),
        .i_underline_on   (o_underline_on),
        .o_fail_count     (chk_fails),
        .o_pending        (chk_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idling is off in every fourth stretch of 50 transfers and over the tail of the run
    assign idle_ok = (n_taken < N_ITEMS - 60) && ((n_taken / 50) % 4 != 3);

    // extended color index: mostly in the color table, some fall back, some oversized
    function automatic t_param pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return t_param'($urandom_range(0, 15));
        end else if (r == 1) begin
            return t_param'($urandom_range(256, 1023));
        end
        return t_param'($urandom_range(16, 255));
    endfunction

    // one ordinary sgr code that changes the attributes
    function automatic t_param pick_plain();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return t_param'(sgr_pkg::SGR_RESET);
        end else if (r <= 7) begin
            case (r)
                1:       return t_param'(sgr_pkg::SGR_BOLD_ON);
                2:       return t_param'(sgr_pkg::SGR_BOLD_OFF);
                3:       return t_param'(sgr_pkg::SGR_NORMAL_INT);
                4:       return t_param'(sgr_pkg::SGR_ITALIC_ON);
                5:       return t_param'(sgr_pkg::SGR_ITALIC_OFF);
                6:       return t_param'(sgr_pkg::SGR_UNDERLINE_ON);
                default: return t_param'(sgr_pkg::SGR_UNDERLINE_OFF);
            endcase
        end else if (r <= 12) begin
            return t_param'($urandom_range(sgr_pkg::SGR_FG_FIRST, sgr_pkg::SGR_FG_LAST));
        end else if (r <= 18) begin
            return t_param'($urandom_range(sgr_pkg::SGR_BG_FIRST, sgr_pkg::SGR_BG_LAST));
        end
        return t_param'(sgr_pkg::SGR_BG_DEFAULT);
    endfunction

    // one random run: plain codes, 38/48;5;n sequences, noise or broken sequences
    task automatic push_sequence();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            param_stream.push_back(pick_plain());
        end else if (kind <= 6) begin
            param_stream.push_back(t_param'($urandom_range(0, 1) ? sgr_pkg::SGR_FG_EXT
                                                                 : sgr_pkg::SGR_BG_EXT));
            param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
            param_stream.push_back(pick_index());
        end else if (kind == 7) begin
            // both requests pending, the foreground one goes first
            param_stream.push_back(t_param'(sgr_pkg::SGR_FG_EXT));
            param_stream.push_back(t_param'(sgr_pkg::SGR_BG_EXT));
            param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
            param_stream.push_back(pick_index());
            if ($urandom_range(0, 1)) begin
                param_stream.push_back(t_param'(sgr_pkg::SGR_BG_EXT));
                param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
                param_stream.push_back(pick_index());
            end
        end else if (kind == 8) begin
            param_stream.push_back(t_param'($urandom_range(0, 1023)));
        end else begin
            // broken sequence: a selector followed by anything, or a stray 5
            if ($urandom_range(0, 2) != 0) begin
                param_stream.push_back(t_param'($urandom_range(0, 1) ? sgr_pkg::SGR_FG_EXT
                                                                     : sgr_pkg::SGR_BG_EXT));
            end
            if ($urandom_range(0, 1)) begin
                param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
            end
            param_stream.push_back($urandom_range(0, 1) ? pick_plain()
                                                        : t_param'($urandom_range(0, 1023)));
        end
    endtask

    // input side: a new parameter is offered once the previous one has transferred
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_param_value <= '0;
            n_taken       <= 0;
        end else begin
            if (i_valid && o_ready) begin
                n_taken <= n_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (next_idx < param_stream.size()) begin
                    i_valid       <= 1'b1;
                    i_param_value <= param_stream[next_idx];
                    next_idx++;
                    // no gaps while the result side is held off, so the block backs up
                    if (idle_ok && !hold_ready && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 18);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off below
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_ready) begin
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (idle_ok && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 18);
            end
        end
    end

    // long hold-off of the result side while parameters keep coming
    initial begin
        wait (n_taken >= 180);
        @(posedge i_clk);
        hold_ready <= 1'b1;
        repeat (90) @(posedge i_clk);
        hold_ready <= 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        // directed part: every attribute code, palette extremes, extended colors
        param_stream.push_back(t_param'(sgr_pkg::SGR_BOLD_ON));
        param_stream.push_back(t_param'(sgr_pkg::SGR_ITALIC_ON));
        param_stream.push_back(t_param'(sgr_pkg::SGR_UNDERLINE_ON));
        param_stream.push_back(t_param'(sgr_pkg::SGR_FG_FIRST));
        param_stream.push_back(t_param'(sgr_pkg::SGR_BG_LAST));
        param_stream.push_back(t_param'(sgr_pkg::SGR_BOLD_OFF));
        param_stream.push_back(t_param'(sgr_pkg::SGR_ITALIC_OFF));
        param_stream.push_back(t_param'(sgr_pkg::SGR_UNDERLINE_OFF));
        param_stream.push_back(t_param'(sgr_pkg::SGR_FG_LAST));
        param_stream.push_back(t_param'(sgr_pkg::SGR_BG_FIRST));
        param_stream.push_back(t_param'(sgr_pkg::SGR_BG_DEFAULT));
        // a 5 outside extended mode does nothing
        param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
        // first cube entry as foreground
        param_stream.push_back(t_param'(sgr_pkg::SGR_FG_EXT));
        param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
        param_stream.push_back(t_param'(sgr_pkg::EXT_BASE));
        // both pending: last cube entry goes to the foreground
        param_stream.push_back(t_param'(sgr_pkg::SGR_FG_EXT));
        param_stream.push_back(t_param'(sgr_pkg::SGR_BG_EXT));
        param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
        param_stream.push_back(t_param'(sgr_pkg::GREY_BASE - 8'd1));
        // oversized index acts as the brightest grey on the background
        param_stream.push_back(t_param'(sgr_pkg::SGR_BG_EXT));
        param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
        param_stream.push_back(t_param'(1023));
        // index below 16 falls back to an ordinary parameter
        param_stream.push_back(t_param'(sgr_pkg::SGR_FG_EXT));
        param_stream.push_back(t_param'(sgr_pkg::SGR_EXT_INDEXED));
        param_stream.push_back(t_param'(sgr_pkg::SGR_BOLD_ON));
        param_stream.push_back(t_param'(sgr_pkg::SGR_NORMAL_INT));
        param_stream.push_back(t_param'(sgr_pkg::SGR_RESET));
        while (param_stream.size() < N_ITEMS) begin
            push_sequence();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every parameter transferred and every result checked
        do begin
            @(posedge i_clk);
        end while (!(n_taken == param_stream.size() && chk_pending == 0));
        repeat (8) @(posedge i_clk);

        if (chk_fails == 0 && chk_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
